/* hdl/triangle_perimeter_area_core_assert.svh */
// ----------------------------------------------------------------------------
// Triangle perimeter/area core - assertion macros
// Shared concurrent assertion forms for the checker of the core.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_PERIMETER_AREA_CORE_ASSERT_SVH
`define TRIANGLE_PERIMETER_AREA_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TPA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TPA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/tpa_pkg.sv */
// ----------------------------------------------------------------------------
// Triangle perimeter/area package
// Result widths, saturation limits and the multiplier pipeline latency.
// ----------------------------------------------------------------------------
package tpa_pkg;

   localparam int PERIM_WIDTH  = 19;
   localparam int AREA_WIDTH   = 31;
   localparam int MULT_LATENCY = 5;

   localparam logic [PERIM_WIDTH-1:0] PERIM_MAX = '1;
   localparam logic [AREA_WIDTH-1:0]  AREA_MAX  = '1;

endpackage

/* hdl/triangle_perimeter_area_core.sv */
// ----------------------------------------------------------------------------
// Triangle perimeter and area core
// Side lengths, perimeter and Heron area of one triangle per request.
// ----------------------------------------------------------------------------
//
//   Channel  | Direction | Handshake           | Payload
//   ---------+-----------+---------------------+-------------------------------
//   req      | in        | req_valid/req_stall | ax, ay, bx, by, cx, cy
//   rsp      | out       | rsp_valid/rsp_stall | valid_res, perimeter, area
//
// One request enters per clock cycle while no response is held back.
// Most of the pipeline depth lies in the two square root pipelines, one
// root bit per stage: COORD_WIDTH+1 stages for the side lengths and
// 2*COORD_WIDTH+6 stages for the area.
// Reset is synchronous and clears every valid bit; data registers keep junk.
// A stall on the response side freezes the whole pipeline at once, and the
// request side is stalled in the same cycle, so no request is dropped or
// repeated. Bubbles move along with the data.
//
// The sides are a = |AB|, b = |BC|, c = |CA|, each the floor square root of
// the exact squared distance. A triangle is valid when the strict triangle
// inequality holds on those floored lengths. The area is
// floor(sqrt(P(P-2a)(P-2b)(P-2c)) / 4), saturated to the 31-bit range.
// Degenerate triangles report a zero perimeter and a zero area.
// ----------------------------------------------------------------------------
module triangle_perimeter_area_core #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [COORD_WIDTH-1:0]        req_ax,
   input  logic signed [COORD_WIDTH-1:0]        req_ay,
   input  logic signed [COORD_WIDTH-1:0]        req_bx,
   input  logic signed [COORD_WIDTH-1:0]        req_by,
   input  logic signed [COORD_WIDTH-1:0]        req_cx,
   input  logic signed [COORD_WIDTH-1:0]        req_cy,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid_res,
   output logic [tpa_pkg::PERIM_WIDTH-1:0]      rsp_perimeter,
   output logic [tpa_pkg::AREA_WIDTH-1:0]       rsp_area
);

   import tpa_pkg::*;

   localparam int MAG_W   = COORD_WIDTH;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int SUM_W   = SQ_W + 1;
   localparam int LEN_W   = COORD_WIDTH + 1;
   localparam int FAC_W   = COORD_WIDTH + 3;
   localparam int ROOT_W  = 2 * FAC_W;
   localparam int AQ_W    = ROOT_W - 2;
   localparam int SIDE_W  = 1 + PERIM_WIDTH;
   localparam int SIDE_D  = MULT_LATENCY + ROOT_W;
   localparam int PCMP_W  = (FAC_W > PERIM_WIDTH) ? FAC_W : PERIM_WIDTH;
   localparam int ACMP_W  = (AQ_W > AREA_WIDTH) ? AQ_W : AREA_WIDTH;

   // Magnitude of q - p, computed one bit wider so it cannot overflow.
   function automatic logic [MAG_W-1:0] abs_diff(
      input logic [COORD_WIDTH-1:0] p,
      input logic [COORD_WIDTH-1:0] q
   );
      logic [COORD_WIDTH:0] d;
      d = {q[COORD_WIDTH-1], q} - {p[COORD_WIDTH-1], p};
      return d[COORD_WIDTH] ? MAG_W'(~d + 1'b1) : MAG_W'(d);
   endfunction

   // Stage 1: coordinate differences, ordered AB x/y, BC x/y, CA x/y.
   logic             s1_valid_ff;
   logic [MAG_W-1:0] mag_ff [6];

   // Stage 2: squares.
   logic             s2_valid_ff;
   logic [SQ_W-1:0]  sq_ff [6];

   // Stage 3: squared side lengths.
   logic                         s3_valid_ff;
   logic [SUM_W-1:0]             sum_ff [3];
   logic [2:0][2*LEN_W-1:0]      side_rad;

   logic                         len_valid;
   logic [2:0][LEN_W-1:0]        len;

   // Stage 4: perimeter and the triangle test.
   logic             s4_valid_ff;
   logic [FAC_W-1:0] p_ff;
   logic [LEN_W-1:0] len_ff [3];
   logic             ok_ff;

   // Stage 5: Heron factors and the side information for the response.
   logic                    s5_valid_ff;
   logic [3:0][FAC_W-1:0]   fac_ff;
   logic [SIDE_W-1:0]       side_ff;
   logic                    p_over;

   logic                    prod_valid;
   logic [4*FAC_W-1:0]      prod;
   logic [0:0][4*FAC_W-1:0] area_rad;
   logic                    root_valid;
   logic [0:0][ROOT_W-1:0]  root;
   logic [SIDE_W-1:0]       side_out;
   logic [AQ_W-1:0]         area_q;
   logic                    area_over;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_res_ff;
   logic [PERIM_WIDTH-1:0]  rsp_perimeter_ff;
   logic [AREA_WIDTH-1:0]   rsp_area_ff;

   // The whole pipeline moves unless a finished response is held back.
   logic en;
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= len_valid;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff[0] <= abs_diff(req_ax, req_bx);
         mag_ff[1] <= abs_diff(req_ay, req_by);
         mag_ff[2] <= abs_diff(req_bx, req_cx);
         mag_ff[3] <= abs_diff(req_by, req_cy);
         mag_ff[4] <= abs_diff(req_cx, req_ax);
         mag_ff[5] <= abs_diff(req_cy, req_ay);
         for (int i = 0; i < 6; i++) begin
            sq_ff[i] <= SQ_W'(mag_ff[i]) * SQ_W'(mag_ff[i]);
         end
         for (int k = 0; k < 3; k++) begin
            sum_ff[k] <= SUM_W'(sq_ff[2*k]) + SUM_W'(sq_ff[2*k+1]);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         side_rad[k] = (2*LEN_W)'(sum_ff[k]);
      end
   end

   tpa_isqrt_pipe #(
      .ROOT_W (LEN_W),
      .LANES  (3)
   ) u_side_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_rad    (side_rad),
      .out_valid (len_valid),
      .out_root  (len)
   );

   // Each strict inequality is checked one bit wider than the lengths.
   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= FAC_W'(len[0]) + FAC_W'(len[1]) + FAC_W'(len[2]);
         for (int k = 0; k < 3; k++) begin
            len_ff[k] <= len[k];
         end
         ok_ff <= ((LEN_W+1)'(len[0]) < (LEN_W+1)'(len[1]) + (LEN_W+1)'(len[2]))
               && ((LEN_W+1)'(len[1]) < (LEN_W+1)'(len[0]) + (LEN_W+1)'(len[2]))
               && ((LEN_W+1)'(len[2]) < (LEN_W+1)'(len[0]) + (LEN_W+1)'(len[1]));
      end
   end

   assign p_over = PCMP_W'(p_ff) > PCMP_W'(PERIM_MAX);

   // For a valid triangle every factor P-2x is positive; otherwise the
   // factors are junk and the result is forced to zero at the end.
   always_ff @(posedge clock) begin
      if (en) begin
         fac_ff[0] <= p_ff;
         for (int k = 0; k < 3; k++) begin
            fac_ff[k+1] <= p_ff - FAC_W'({len_ff[k], 1'b0});
         end
         if (!ok_ff) begin
            side_ff <= '0;
         end else if (p_over) begin
            side_ff <= {1'b1, PERIM_MAX};
         end else begin
            side_ff <= {1'b1, PERIM_WIDTH'(p_ff)};
         end
      end
   end

   tpa_mult_pipe #(
      .FAC_W (FAC_W)
   ) u_mult (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s5_valid_ff),
      .in_fac    (fac_ff),
      .out_valid (prod_valid),
      .out_prod  (prod)
   );

   assign area_rad[0] = prod;

   tpa_isqrt_pipe #(
      .ROOT_W (ROOT_W),
      .LANES  (1)
   ) u_area_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (prod_valid),
      .in_rad    (area_rad),
      .out_valid (root_valid),
      .out_root  (root)
   );

   // The triangle flag and perimeter ride alongside the product and root.
   tpa_delay #(
      .WIDTH (SIDE_W),
      .DEPTH (SIDE_D)
   ) u_side_delay (
      .clock    (clock),
      .en       (en),
      .in_data  (side_ff),
      .out_data (side_out)
   );

   assign area_q    = root[0][ROOT_W-1:2];
   assign area_over = ACMP_W'(area_q) > ACMP_W'(AREA_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= root_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_valid_res_ff <= side_out[SIDE_W-1];
         rsp_perimeter_ff <= side_out[PERIM_WIDTH-1:0];
         if (!side_out[SIDE_W-1]) begin
            rsp_area_ff <= '0;
         end else if (area_over) begin
            rsp_area_ff <= AREA_MAX;
         end else begin
            rsp_area_ff <= AREA_WIDTH'(area_q);
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_valid_res_ff;
   assign rsp_perimeter = rsp_perimeter_ff;
   assign rsp_area      = rsp_area_ff;

endmodule

/* hdl/tpa_isqrt_pipe.sv */
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per register stage, restoring digit recurrence, several lanes.
// ----------------------------------------------------------------------------
module tpa_isqrt_pipe #(
   parameter int ROOT_W = 17,
   parameter int LANES  = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [LANES-1:0][2*ROOT_W-1:0]       in_rad,
   output logic                                 out_valid,
   output logic [LANES-1:0][ROOT_W-1:0]         out_root
);

   localparam int RAD_W = 2 * ROOT_W;
   localparam int RMW   = ROOT_W + 3;

   logic                           valid_ff [ROOT_W];
   logic [LANES-1:0][RMW-1:0]      rem_ff   [ROOT_W];
   logic [LANES-1:0][ROOT_W-1:0]   root_ff  [ROOT_W];
   logic [LANES-1:0][RAD_W-1:0]    rad_ff   [ROOT_W];

   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      logic                         valid_prev;
      logic [LANES-1:0][RMW-1:0]    rem_prev, rem_in;
      logic [LANES-1:0][ROOT_W-1:0] root_prev, root_in;
      logic [LANES-1:0][RAD_W-1:0]  rad_prev, rad_in;

      if (s == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign rad_prev   = in_rad;
      end else begin : g_next
         assign valid_prev = valid_ff[s-1];
         assign rem_prev   = rem_ff[s-1];
         assign root_prev  = root_ff[s-1];
         assign rad_prev   = rad_ff[s-1];
      end

      // Bring down the next two radicand bits and try to subtract 4r+1.
      always_comb begin
         logic [RMW-1:0] cand;
         logic [RMW-1:0] trial;
         for (int l = 0; l < LANES; l++) begin
            cand  = {rem_prev[l][RMW-3:0], rad_prev[l][RAD_W-1 -: 2]};
            trial = RMW'({root_prev[l], 2'b01});
            if (cand >= trial) begin
               rem_in[l]  = cand - trial;
               root_in[l] = {root_prev[l][ROOT_W-2:0], 1'b1};
            end else begin
               rem_in[l]  = cand;
               root_in[l] = {root_prev[l][ROOT_W-2:0], 1'b0};
            end
            rad_in[l] = {rad_prev[l][RAD_W-3:0], 2'b00};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            rad_ff[s]  <= rad_in;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];

endmodule

/* hdl/tpa_delay.sv */
// ----------------------------------------------------------------------------
// Enabled delay line
// Carries side information alongside a pipeline of equal depth.
// ----------------------------------------------------------------------------
module tpa_delay #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 43
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] in_data,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= in_data;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign out_data = line_ff[DEPTH-1];

endmodule

/* hdl/tpa_mult_pipe.sv */
// ----------------------------------------------------------------------------
// Four-factor product pipeline
// Forms f0*f1*f2*f3 with partial products of factor width by factor width.
// ----------------------------------------------------------------------------
module tpa_mult_pipe #(
   parameter int FAC_W = 19
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [3:0][FAC_W-1:0]       in_fac,
   output logic                        out_valid,
   output logic [4*FAC_W-1:0]          out_prod
);

   import tpa_pkg::*;

   localparam int P2_W = 2 * FAC_W;
   localparam int P3_W = 3 * FAC_W;
   localparam int P4_W = 4 * FAC_W;

   logic [MULT_LATENCY-1:0] valid_ff;

   logic [P2_W-1:0]  x1_ff;
   logic [FAC_W-1:0] f2_ff, f3_s1_ff, f3_s2_ff, f3_s3_ff;
   logic [P2_W-1:0]  pa_ff, pb_ff;
   logic [P3_W-1:0]  x2_ff;
   logic [P2_W-1:0]  q0_ff, q1_ff, q2_ff;
   logic [P4_W-1:0]  x3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[MULT_LATENCY-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff    <= P2_W'(in_fac[0]) * P2_W'(in_fac[1]);
         f2_ff    <= in_fac[2];
         f3_s1_ff <= in_fac[3];

         pa_ff    <= P2_W'(x1_ff[FAC_W-1:0]) * P2_W'(f2_ff);
         pb_ff    <= P2_W'(x1_ff[P2_W-1:FAC_W]) * P2_W'(f2_ff);
         f3_s2_ff <= f3_s1_ff;

         x2_ff    <= P3_W'(pa_ff) + {pb_ff, {FAC_W{1'b0}}};
         f3_s3_ff <= f3_s2_ff;

         q0_ff    <= P2_W'(x2_ff[FAC_W-1:0]) * P2_W'(f3_s3_ff);
         q1_ff    <= P2_W'(x2_ff[P2_W-1:FAC_W]) * P2_W'(f3_s3_ff);
         q2_ff    <= P2_W'(x2_ff[P3_W-1:P2_W]) * P2_W'(f3_s3_ff);

         x3_ff    <= P4_W'(q0_ff) + P4_W'({q1_ff, {FAC_W{1'b0}}})
                     + {q2_ff, {P2_W{1'b0}}};
      end
   end

   assign out_valid = valid_ff[MULT_LATENCY-1];
   assign out_prod  = x3_ff;

endmodule

/* hdl/tpa_checker.sv */
// ----------------------------------------------------------------------------
// Triangle perimeter/area checker
// Port-level assertions on the core, attached by bind.
// ----------------------------------------------------------------------------
`include "triangle_perimeter_area_core_assert.svh"

module tpa_checker #(
   parameter int COORD_WIDTH = 16
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic [COORD_WIDTH-1:0]           req_ax,
   input logic [COORD_WIDTH-1:0]           req_ay,
   input logic [COORD_WIDTH-1:0]           req_bx,
   input logic [COORD_WIDTH-1:0]           req_by,
   input logic [COORD_WIDTH-1:0]           req_cx,
   input logic [COORD_WIDTH-1:0]           req_cy,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic                             rsp_valid_res,
   input logic [tpa_pkg::PERIM_WIDTH-1:0]  rsp_perimeter,
   input logic [tpa_pkg::AREA_WIDTH-1:0]   rsp_area
);

   import tpa_pkg::*;

   logic req_seen;
   assign req_seen = req_valid && (req_ax == req_ax) && (req_ay == req_ay)
                  && (req_bx == req_bx) && (req_by == req_by)
                  && (req_cx == req_cx) && (req_cy == req_cy);

   // A degenerate triangle reports nothing but zeros.
   `TPA_ASSERT_IMP(a_degenerate_zero, clock, reset, rsp_valid && !rsp_valid_res, (rsp_perimeter == '0) && (rsp_area == '0), "degenerate response with nonzero perimeter or area")

   // A valid triangle always has a positive perimeter.
   `TPA_ASSERT_IMP(a_valid_perimeter, clock, reset, rsp_valid && rsp_valid_res, rsp_perimeter != '0, "valid triangle with zero perimeter")

   // A held response must back-pressure the request side in the same cycle.
   `TPA_ASSERT_IMP(a_backpressure, clock, reset, (req_seen || !req_valid) && rsp_valid && rsp_stall, req_stall, "request side open while response is held")

   // A stalled response stays put.
   `TPA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_valid_res) && $stable(rsp_perimeter) && $stable(rsp_area), "stalled response changed")

endmodule

bind triangle_perimeter_area_core tpa_checker #(.COORD_WIDTH(COORD_WIDTH)) u_checker (.*);

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Triangle perimeter and area core testbench
// Sends triangles through the core, predicts each response with an
// independent Heron model and compares every field in order.
// ----------------------------------------------------------------------------
module tb;

   import tpa_pkg::*;

   localparam int CW        = 16;
   localparam int LATENCY   = 3*CW + 18;
   localparam int MAX_CYCLE = 400000;

   typedef struct packed {
      logic                   ok;
      logic [PERIM_WIDTH-1:0] perim;
      logic [AREA_WIDTH-1:0]  area;
   } tri_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [CW-1:0] req_ax = '0, req_ay = '0, req_bx = '0;
   logic signed [CW-1:0] req_by = '0, req_cx = '0, req_cy = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_valid_res;
   logic [PERIM_WIDTH-1:0] rsp_perimeter;
   logic [AREA_WIDTH-1:0]  rsp_area;

   tri_rsp_type expected_q[$];
   int       mismatches = 0;
   int       cycles = 0;
   bit       quiet = 1'b0;     // no idling in the last part of the run
   int       hold_off = 0;     // long receiver hold-off, in cycles

   triangle_perimeter_area_core #(.COORD_WIDTH(CW)) u_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Floor square root of an unsigned 128-bit value, one root bit at a time.
   function automatic logic [63:0] floor_sqrt(input logic [127:0] x);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if ({64'd0, t} * {64'd0, t} <= x) r = t;
      end
      return r;
   endfunction

   function automatic logic [63:0] side_len(input logic signed [CW-1:0] x0, y0, x1, y1);
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      dx = 64'(x1) - 64'(x0);
      dy = 64'(y1) - 64'(y0);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return floor_sqrt(128'(dx*dx) + 128'(dy*dy));
   endfunction

   // Heron area in whole square units; the 64-bit sides keep every product below
   // 2^128 at this coordinate width, so only the 31-bit saturation applies.
   function automatic tri_rsp_type heron_predict(input logic signed [CW-1:0] ax, ay, bx, by,
                                                 cx, cy);
      logic [63:0]  la, lb, lc, p, ar;
      logic [127:0] prod;
      tri_rsp_type  r;
      la = side_len(ax, ay, bx, by);
      lb = side_len(bx, by, cx, cy);
      lc = side_len(cx, cy, ax, ay);
      p  = la + lb + lc;
      r  = '0;
      if (la < lb + lc && lb < la + lc && lc < la + lb) begin
         prod = 128'(p) * 128'(p - 2*la) * 128'(p - 2*lb) * 128'(p - 2*lc);
         ar = floor_sqrt(prod) >> 2;
         r.ok    = 1'b1;
         r.perim = (p > PERIM_MAX) ? PERIM_MAX : p[PERIM_WIDTH-1:0];
         r.area  = (ar > AREA_MAX) ? AREA_MAX : ar[AREA_WIDTH-1:0];
      end
      return r;
   endfunction

   // Offers one request, with an optional random idle burst before it, and
   // holds it until the core accepts it.
   task automatic send_triangle(input logic signed [CW-1:0] ax, ay, bx, by, cx, cy);
      int gap;
      if (!quiet && $urandom_range(3) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ax <= ax; req_ay <= ay; req_bx <= bx;
      req_by <= by; req_cx <= cx; req_cy <= cy;
      expected_q.push_back(heron_predict(ax, ay, bx, by, cx, cy));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic idle_request();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [CW-1:0] rnd_coord();
      case ($urandom_range(3))
         0:       return CW'($urandom);
         1:       return CW'($signed($urandom_range(64)) - 32);
         2:       return $urandom_range(1) ? 16'sh7fff - CW'($urandom_range(15))
                                           : 16'sh8000 + CW'($urandom_range(15));
         default: return CW'($signed($urandom_range(2048)) - 1024);
      endcase
   endfunction

   // Extremes, degenerate and coincident shapes and the largest triangles.
   task automatic test_directed();
      send_triangle(0, 0, 0, 0, 0, 0);
      send_triangle(0, 0, 16, 0, 32, 0);
      send_triangle(5, 5, 5, 5, 100, 7);
      send_triangle(0, 0, 48, 0, 0, 64);
      send_triangle(0, 0, 1, 0, 0, 1);
      send_triangle(0, 0, 2, 0, 1, 1);
      send_triangle(-32768, -32768, 32767, -32768, -32768, 32767);
      send_triangle(-32768, -32768, 32767, 32767, -32768, 32767);
      send_triangle(32767, 32767, -32768, 32767, 32767, -32768);
      send_triangle(-32768, 0, 32767, 0, 0, 32767);
      send_triangle(-32768, -32768, 32767, 32767, 0, 0);
      send_triangle(-1, -1, -1, -1, -1, -1);
      send_triangle(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555, 16'sh0f0f, 16'shf0f0);
      send_triangle(16'shaaaa, 16'sh5555, 16'sh5555, 16'shaaaa, 16'shf0f0, 16'sh0f0f);
      send_triangle(0, 0, 1000, 0, 500, 1);
      send_triangle(0, 0, 3, 0, 1, 0);
      idle_request();
   endtask

   // Mostly well-formed random triangles, with some near-degenerate ones.
   task automatic test_random(input int count);
      logic signed [CW-1:0] ax, ay, bx, by;
      for (int i = 0; i < count; i++) begin
         ax = rnd_coord(); ay = rnd_coord(); bx = rnd_coord(); by = rnd_coord();
         if ($urandom_range(9) == 0)
            send_triangle(ax, ay, bx, by, ax + (bx - ax) / 2, ay + (by - ay) / 2);
         else
            send_triangle(ax, ay, bx, by, rnd_coord(), rnd_coord());
      end
      idle_request();
   endtask

   // The receiver holds off while the sender keeps offering requests, so the
   // pipeline fills up and the core stalls its request side.
   task automatic test_backpressure();
      hold_off = 200;
      test_random(100);
   endtask

   // Response side: random stall bursts, the long hold-off, and the checker.
   initial begin
      int burst;
      burst = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > MAX_CYCLE) begin
            $display("RESULT: ERROR");
            $finish;
         end
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response at cycle %0d", cycles);
            end else begin
               tri_rsp_type e;
               e = expected_q.pop_front();
               if (e.ok !== rsp_valid_res || e.perim !== rsp_perimeter ||
                   e.area !== rsp_area) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp ok=%0d p=%0d a=%0d got ok=%0d p=%0d a=%0d",
                              e.ok, e.perim, e.area, rsp_valid_res, rsp_perimeter,
                              rsp_area);
               end
            end
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_stall <= 1'b1;
         end else if (burst > 0) begin
            burst--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(5) == 0) begin
            burst = $urandom_range(1, 11) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int wait_cycles;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(500);
      test_backpressure();
      quiet = 1'b1;
      test_random(200);
      wait_cycles = 0;
      while (expected_q.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
